// ===== hw/rtl/imuocs_pkg.sv =====
// ----------------------------------------------------------------------------
// imuocs_pkg: shared types and constants for the IMU offset calibration unit
// Field widths, fixed-point limits and the lane control struct.
// ----------------------------------------------------------------------------
package imuocs_pkg;

    // field and state widths
    localparam int unsigned RAW_W  = 16;
    localparam int unsigned OUT_W  = 17;
    localparam int unsigned SENS_W = 16;
    localparam int unsigned SUM_W  = 23;

    // default averaging window
    localparam int unsigned SAMPLES_DEF = 64;

    // sensitivity after reset, Q8.8
    localparam logic [SENS_W-1:0] SENS_RESET = 16'd573;

    // gyro deadband, rate clamp (Q8.8), one g and accel clamp (Q2.14)
    localparam int unsigned DEADBAND   = 1000;
    localparam int unsigned RATE_LIMIT = 64000;
    localparam int unsigned ONE_G      = 16384;
    localparam int unsigned G_LIMIT    = 32768;

    // reciprocal shift for the divide by the window size
    localparam int unsigned DIV_SHIFT = 29;

    // per-request lane commands from the control logic
    typedef struct packed {
        logic clear;    // drop sums and offsets
        logic accum;    // add sample into sums
        logic average;  // turn sums into offsets
        logic load;     // capture corrected sample into the lane stage
    } t_lane_ctl;

endpackage

// ===== hw/rtl/imuocs_lane.sv =====
// ----------------------------------------------------------------------------
// imuocs_lane: one axis of the IMU offset calibration unit
// Holds the gyro and accel offset of its axis, sums and averages them, and
// corrects, deadbands, scales and clamps one sample in two steps.
// ----------------------------------------------------------------------------
module imuocs_lane #(
    parameter int unsigned SAMPLES = imuocs_pkg::SAMPLES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  imuocs_pkg::t_lane_ctl                   i_ctl,
    input  logic                                    i_sub_one_g,
    input  logic        [imuocs_pkg::SENS_W-1:0]    i_sens,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_gyro,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_accel,
    output logic signed [imuocs_pkg::OUT_W-1:0]     o_rate,
    output logic signed [imuocs_pkg::OUT_W-1:0]     o_gravity
);
    import imuocs_pkg::*;

    localparam int unsigned MulW  = DIV_SHIFT + 1;
    localparam int unsigned DiffW = SUM_W + 1;
    localparam int unsigned ProdW = (SUM_W - 1) + MulW;
    localparam logic [MulW-1:0] DivMul =
        MulW'(((64'd1 << DIV_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
    localparam logic signed [DiffW-1:0] DbLim   = DiffW'(DEADBAND);
    localparam logic signed [DiffW-1:0] OneG    = DiffW'(ONE_G);
    localparam logic signed [DiffW-1:0] GLim    = DiffW'(G_LIMIT);
    localparam logic [24:0]             RateLim = 25'(RATE_LIMIT);

    logic signed [SUM_W-1:0] r_gyro_off, n_gyro_off;
    logic signed [SUM_W-1:0] r_accel_off, n_accel_off;
    logic        [OUT_W-1:0] r_mag;
    logic                    r_neg;
    logic signed [OUT_W-1:0] r_grav;

    logic signed [SUM_W-1:0] gyro_avg, accel_avg;
    logic signed [DiffW-1:0] d_gyro, d_accel, abs_gyro;
    logic        [OUT_W-1:0] mag;
    logic signed [OUT_W-1:0] grav_sat;
    logic        [32:0]      scaled;
    logic        [24:0]      shifted;
    logic        [OUT_W-1:0] clamped;

    // divide a sum by the window, truncating toward zero
    function automatic logic signed [SUM_W-1:0] avg_of(input logic signed [SUM_W-1:0] sum);
        logic             neg;
        logic [SUM_W-1:0] smag;
        logic [ProdW-1:0] prod;
        logic [SUM_W-1:0] q;
        neg  = sum[SUM_W-1];
        smag = neg ? SUM_W'(-sum) : SUM_W'(sum);
        prod = ProdW'(smag[SUM_W-2:0]) * ProdW'(DivMul);
        q    = prod[DIV_SHIFT +: SUM_W];
        return neg ? signed'(SUM_W'(-q)) : signed'(q);
    endfunction

    assign gyro_avg  = avg_of(r_gyro_off);
    assign accel_avg = avg_of(r_accel_off);

    // update sums and offsets
    always_comb begin
        n_gyro_off  = r_gyro_off;
        n_accel_off = r_accel_off;
        if (i_ctl.clear) begin
            n_gyro_off  = '0;
            n_accel_off = '0;
        end else if (i_ctl.accum) begin
            n_gyro_off  = r_gyro_off + SUM_W'(i_gyro);
            n_accel_off = r_accel_off + SUM_W'(i_accel);
        end else if (i_ctl.average) begin
            n_gyro_off  = gyro_avg;
            n_accel_off = accel_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_off  <= '0;
            r_accel_off <= '0;
        end else begin
            r_gyro_off  <= n_gyro_off;
            r_accel_off <= n_accel_off;
        end
    end

    // correct the sample, apply deadband and accel saturation
    always_comb begin
        d_gyro  = DiffW'(i_gyro) - DiffW'(r_gyro_off);
        d_accel = DiffW'(i_accel) - DiffW'(r_accel_off) - (i_sub_one_g ? OneG : '0);
        abs_gyro = d_gyro[DiffW-1] ? -d_gyro : d_gyro;
        if (d_gyro > -DbLim && d_gyro < DbLim) begin
            mag = '0;
        end else begin
            mag = abs_gyro[OUT_W-1:0];
        end
        if (d_accel > GLim) begin
            grav_sat = OUT_W'(GLim);
        end else if (d_accel < -GLim) begin
            grav_sat = OUT_W'(-GLim);
        end else begin
            grav_sat = d_accel[OUT_W-1:0];
        end
    end

    // hold the corrected sample for the scaling step
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mag  <= mag;
            r_neg  <= d_gyro[DiffW-1];
            r_grav <= grav_sat;
        end
    end

    // scale the gyro magnitude, clamp and restore the sign
    always_comb begin
        scaled  = 33'(r_mag) * 33'(i_sens);
        shifted = scaled[32:8];
        clamped = (shifted > RateLim) ? OUT_W'(RateLim) : shifted[OUT_W-1:0];
        o_rate  = r_neg ? signed'(OUT_W'(-clamped)) : signed'(clamped);
    end

    assign o_gravity = r_grav;

endmodule

// ===== hw/rtl/imu_offset_calibrate_scale_unit.sv =====
// ----------------------------------------------------------------------------
// imu_offset_calibrate_scale_unit: IMU zero-offset calibration and scaling
// Averages the first SAMPLES samples into per-axis offsets, then corrects
// each sample, deadbands and scales the gyro, and saturates the accel.
//
//   channel   signals                                  direction
//   in        i_in_valid / o_in_ready, i_recalibrate,  sample in
//             i_gyro_*, i_accel_*
//   out       o_out_valid / i_out_ready, o_rate_*,     result out
//             o_gravity_*
//   cfg       i_cfg_we, i_cfg_wdata                    sensitivity write
//
// One request per cycle unless the output stalls. A result passes through the
// lane stage and then the output register. Calibration and recalibrate
// requests update the offsets in the cycle they are accepted and give no
// result. Reset clears offsets and counter. When the output stalls, one more
// request is taken into the lane stage.
// ----------------------------------------------------------------------------
module imu_offset_calibrate_scale_unit #(
    parameter int unsigned SAMPLES = imuocs_pkg::SAMPLES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic        [imuocs_pkg::SENS_W-1:0]    i_cfg_wdata,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_recalibrate,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_gyro_x,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_gyro_y,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_gyro_z,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_accel_x,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_accel_y,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_accel_z,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [imuocs_pkg::OUT_W-1:0]     o_rate_x,
    output logic signed [imuocs_pkg::OUT_W-1:0]     o_rate_y,
    output logic signed [imuocs_pkg::OUT_W-1:0]     o_rate_z,
    output logic signed [imuocs_pkg::OUT_W-1:0]     o_gravity_x,
    output logic signed [imuocs_pkg::OUT_W-1:0]     o_gravity_y,
    output logic signed [imuocs_pkg::OUT_W-1:0]     o_gravity_z
);
    import imuocs_pkg::*;

    localparam int unsigned CntW = $clog2(SAMPLES + 1);

    logic [SENS_W-1:0] r_sens;
    logic [CntW-1:0]   r_count, n_count;
    logic              r_calibrated, n_calibrated;
    logic              r_s1_valid, n_s1_valid;
    logic              r_out_valid, n_out_valid;
    logic signed [OUT_W-1:0] r_rate [3];
    logic signed [OUT_W-1:0] r_grav [3];

    logic              accept, out_free;
    t_lane_ctl         ctl;
    logic signed [RAW_W-1:0] gyro_in  [3];
    logic signed [RAW_W-1:0] accel_in [3];
    logic signed [OUT_W-1:0] lane_rate [3];
    logic signed [OUT_W-1:0] lane_grav [3];

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || out_free;
    assign accept     = i_in_valid && o_in_ready;

    // sensitivity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= SENS_RESET;
        end else if (i_cfg_we) begin
            r_sens <= i_cfg_wdata;
        end
    end

    // decide what the accepted request does to the lanes
    always_comb begin
        ctl          = '0;
        n_count      = r_count;
        n_calibrated = r_calibrated;
        if (accept) begin
            if (i_recalibrate) begin
                ctl.clear    = 1'b1;
                n_count      = '0;
                n_calibrated = 1'b0;
            end else if (r_count < CntW'(SAMPLES)) begin
                ctl.accum = 1'b1;
                n_count   = r_count + 1'b1;
            end else if (!r_calibrated) begin
                ctl.average  = 1'b1;
                n_calibrated = 1'b1;
            end else begin
                ctl.load = 1'b1;
            end
        end
        n_s1_valid  = ctl.load || (r_s1_valid && !out_free);
        n_out_valid = out_free ? r_s1_valid : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_calibrated <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_calibrated <= n_calibrated;
            r_s1_valid   <= n_s1_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign gyro_in[0]  = i_gyro_x;
    assign gyro_in[1]  = i_gyro_y;
    assign gyro_in[2]  = i_gyro_z;
    assign accel_in[0] = i_accel_x;
    assign accel_in[1] = i_accel_y;
    assign accel_in[2] = i_accel_z;

    // one lane per axis; z removes one g from the accel
    for (genvar a = 0; a < 3; a++) begin : g_lane
        imuocs_lane #(
            .SAMPLES (SAMPLES)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_sub_one_g (a == 2),
            .i_sens      (r_sens),
            .i_gyro      (gyro_in[a]),
            .i_accel     (accel_in[a]),
            .o_rate      (lane_rate[a]),
            .o_gravity   (lane_grav[a])
        );
    end

    // merge lane results into the output register
    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_rate[k] <= lane_rate[k];
                r_grav[k] <= lane_grav[k];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rate_x    = r_rate[0];
    assign o_rate_y    = r_rate[1];
    assign o_rate_z    = r_rate[2];
    assign o_gravity_x = r_grav[0];
    assign o_gravity_y = r_grav[1];
    assign o_gravity_z = r_grav[2];

endmodule

// ===== tb/sv/imuocs_checker.sv =====
// ----------------------------------------------------------------------------
// imuocs_checker: result predictor and scoreboard for the IMU offset unit
// Watches the request, result and register ports, keeps its own copy of the
// calibration state, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module imuocs_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic        [imuocs_pkg::SENS_W-1:0]    i_cfg_wdata,
    input  logic                                    i_in_valid,
    input  logic                                    i_in_ready,
    input  logic                                    i_recalibrate,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_gyro_x,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_gyro_y,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_gyro_z,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_accel_x,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_accel_y,
    input  logic signed [imuocs_pkg::RAW_W-1:0]     i_accel_z,
    input  logic                                    i_out_valid,
    input  logic                                    i_out_ready,
    input  logic signed [imuocs_pkg::OUT_W-1:0]     i_rate_x,
    input  logic signed [imuocs_pkg::OUT_W-1:0]     i_rate_y,
    input  logic signed [imuocs_pkg::OUT_W-1:0]     i_rate_z,
    input  logic signed [imuocs_pkg::OUT_W-1:0]     i_gravity_x,
    input  logic signed [imuocs_pkg::OUT_W-1:0]     i_gravity_y,
    input  logic signed [imuocs_pkg::OUT_W-1:0]     i_gravity_z,
    output int                                      o_fail_count,
    output int                                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import imuocs_pkg::*;

    // signed copies of the package limits
    localparam int     WINDOW    = SAMPLES_DEF;
    localparam int     DEAD      = DEADBAND;
    localparam longint RATE_MAX  = RATE_LIMIT;
    localparam int     GRAV_MAX  = G_LIMIT;
    localparam int     GRAV_BIAS = ONE_G;
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic signed [OUT_W-1:0] rate_x;
        logic signed [OUT_W-1:0] rate_y;
        logic signed [OUT_W-1:0] rate_z;
        logic signed [OUT_W-1:0] gravity_x;
        logic signed [OUT_W-1:0] gravity_y;
        logic signed [OUT_W-1:0] gravity_z;
    } t_motion_result;

    t_motion_result          motion_q[$];
    logic [SENS_W-1:0]       sensitivity;
    int                      window_count;
    logic                    offsets_ready;
    logic signed [SUM_W-1:0] gyro_acc[3];
    logic signed [SUM_W-1:0] accel_acc[3];
    int                      fail_count;

    assign o_fail_count = fail_count;

    // drop the sums and restart the averaging window
    task automatic clear_calibration();
        window_count  = 0;
        offsets_ready = 1'b0;
        for (int k = 0; k < 3; k++) begin
            gyro_acc[k]  = '0;
            accel_acc[k] = '0;
        end
    endtask

    // deadband, scale by sensitivity, clamp to the rate limit
    function automatic logic signed [OUT_W-1:0] scaled_rate(input int raw, input int offset);
        int     delta;
        longint mag;
        delta = raw - offset;
        if (delta > -DEAD && delta < DEAD) begin
            delta = 0;
        end
        mag = (delta < 0) ? -longint'(delta) : longint'(delta);
        mag = (mag * longint'(sensitivity)) >>> 8;
        if (mag > RATE_MAX) begin
            mag = RATE_MAX;
        end
        if (delta < 0) begin
            mag = -mag;
        end
        return mag[OUT_W-1:0];
    endfunction

    // remove offset and bias, saturate to two g
    function automatic logic signed [OUT_W-1:0] saturated_gravity(input int raw,
                                                                  input int offset,
                                                                  input int bias);
        int delta;
        delta = raw - offset - bias;
        if (delta > GRAV_MAX) begin
            delta = GRAV_MAX;
        end
        if (delta < -GRAV_MAX) begin
            delta = -GRAV_MAX;
        end
        return delta[OUT_W-1:0];
    endfunction

    // advance the calibration state by one request, queue its result if any
    task automatic take_request();
        int             gyro_raw[3];
        int             accel_raw[3];
        t_motion_result motion;
        gyro_raw[0]  = i_gyro_x;
        gyro_raw[1]  = i_gyro_y;
        gyro_raw[2]  = i_gyro_z;
        accel_raw[0] = i_accel_x;
        accel_raw[1] = i_accel_y;
        accel_raw[2] = i_accel_z;
        if (i_recalibrate) begin
            clear_calibration();
        end else if (window_count < WINDOW) begin
            window_count++;
            for (int k = 0; k < 3; k++) begin
                gyro_acc[k]  = gyro_acc[k] + SUM_W'(gyro_raw[k]);
                accel_acc[k] = accel_acc[k] + SUM_W'(accel_raw[k]);
            end
        end else if (!offsets_ready) begin
            // average with truncation toward zero
            offsets_ready = 1'b1;
            for (int k = 0; k < 3; k++) begin
                gyro_acc[k]  = SUM_W'(int'(gyro_acc[k]) / WINDOW);
                accel_acc[k] = SUM_W'(int'(accel_acc[k]) / WINDOW);
            end
        end else begin
            motion.rate_x    = scaled_rate(gyro_raw[0], gyro_acc[0]);
            motion.rate_y    = scaled_rate(gyro_raw[1], gyro_acc[1]);
            motion.rate_z    = scaled_rate(gyro_raw[2], gyro_acc[2]);
            motion.gravity_x = saturated_gravity(accel_raw[0], accel_acc[0], 0);
            motion.gravity_y = saturated_gravity(accel_raw[1], accel_acc[1], 0);
            motion.gravity_z = saturated_gravity(accel_raw[2], accel_acc[2], GRAV_BIAS);
            motion_q.push_back(motion);
        end
    endtask

    task automatic compare_field(input string name,
                                 input logic signed [OUT_W-1:0] want,
                                 input logic signed [OUT_W-1:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $realtime, name,
                         want, got);
            end
        end
    endtask

    // match the delivered result against the oldest prediction
    task automatic check_result();
        t_motion_result want;
        if (motion_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
                $display("%0t: result with no request pending: rate %0d %0d %0d, gravity %0d %0d %0d",
                         $realtime, i_rate_x, i_rate_y, i_rate_z,
                         i_gravity_x, i_gravity_y, i_gravity_z);
            end
        end else begin
            want = motion_q.pop_front();
            compare_field("rate_x", want.rate_x, i_rate_x);
            compare_field("rate_y", want.rate_y, i_rate_y);
            compare_field("rate_z", want.rate_z, i_rate_z);
            compare_field("gravity_x", want.gravity_x, i_gravity_x);
            compare_field("gravity_y", want.gravity_y, i_gravity_y);
            compare_field("gravity_z", want.gravity_z, i_gravity_z);
        end
    endtask

    initial begin
        fail_count = 0;
        sensitivity = SENS_RESET;
        clear_calibration();
    end

    // sample every port at the edge: results first, then requests, then register
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sensitivity = SENS_RESET;
            clear_calibration();
            motion_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_in_valid && i_in_ready) begin
                take_request();
            end
            if (i_cfg_we) begin
                sensitivity = i_cfg_wdata;
            end
        end
        o_pending <= motion_q.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the IMU offset calibration and scaling unit
// Drives calibration windows, recalibrate requests and corrected samples with
// random gaps and output stalls, rewrites the gyro sensitivity between runs,
// and gives the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import imuocs_pkg::*;

    localparam int WINDOW        = SAMPLES_DEF;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CALM_TAIL     = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;

    typedef struct packed {
        logic                    recal;
        logic signed [RAW_W-1:0] gyro_x;
        logic signed [RAW_W-1:0] gyro_y;
        logic signed [RAW_W-1:0] gyro_z;
        logic signed [RAW_W-1:0] accel_x;
        logic signed [RAW_W-1:0] accel_y;
        logic signed [RAW_W-1:0] accel_z;
    } t_imu_reading;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [SENS_W-1:0]       cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    recalibrate = 1'b0;
    logic signed [RAW_W-1:0] gyro_x = '0;
    logic signed [RAW_W-1:0] gyro_y = '0;
    logic signed [RAW_W-1:0] gyro_z = '0;
    logic signed [RAW_W-1:0] accel_x = '0;
    logic signed [RAW_W-1:0] accel_y = '0;
    logic signed [RAW_W-1:0] accel_z = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [OUT_W-1:0] rate_x, rate_y, rate_z;
    logic signed [OUT_W-1:0] gravity_x, gravity_y, gravity_z;
    int                      fail_count;
    int                      pending;

    bit idle_on = 1'b1;
    int stall_left = 0;
    int readings_sent = 0;
    int gyro_bias[3];
    int accel_bias[3];

    always #2 clk = ~clk;

    imu_offset_calibrate_scale_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_recalibrate (recalibrate),
        .i_gyro_x      (gyro_x),
        .i_gyro_y      (gyro_y),
        .i_gyro_z      (gyro_z),
        .i_accel_x     (accel_x),
        .i_accel_y     (accel_y),
        .i_accel_z     (accel_z),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_rate_x      (rate_x),
        .o_rate_y      (rate_y),
        .o_rate_z      (rate_z),
        .o_gravity_x   (gravity_x),
        .o_gravity_y   (gravity_y),
        .o_gravity_z   (gravity_z)
    );

    imuocs_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_recalibrate (recalibrate),
        .i_gyro_x      (gyro_x),
        .i_gyro_y      (gyro_y),
        .i_gyro_z      (gyro_z),
        .i_accel_x     (accel_x),
        .i_accel_y     (accel_y),
        .i_accel_z     (accel_z),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_rate_x      (rate_x),
        .i_rate_y      (rate_y),
        .i_rate_z      (rate_z),
        .i_gravity_x   (gravity_x),
        .i_gravity_y   (gravity_y),
        .i_gravity_z   (gravity_z),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    function automatic logic signed [RAW_W-1:0] sat16(input int v);
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return v[RAW_W-1:0];
    endfunction

    function automatic t_imu_reading make_reading(input bit recal, input int gx, input int gy,
                                                  input int gz, input int ax, input int ay,
                                                  input int az);
        t_imu_reading r;
        r.recal   = recal;
        r.gyro_x  = sat16(gx);
        r.gyro_y  = sat16(gy);
        r.gyro_z  = sat16(gz);
        r.accel_x = sat16(ax);
        r.accel_y = sat16(ay);
        r.accel_z = sat16(az);
        return r;
    endfunction

    // mostly near the center, now and then any 16-bit value
    function automatic int axis_value(input int center, input int spread);
        if ($urandom_range(0, 7) == 0) begin
            return int'($urandom_range(0, 65535)) - 32768;
        end
        return center + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic t_imu_reading noise_reading(input bit recal);
        t_imu_reading r;
        r       = t_imu_reading'($urandom_range(0, 65535));
        r       = {recal, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom)};
        return r;
    endfunction

    function automatic t_imu_reading window_reading(input int spread);
        return make_reading(1'b0,
                            axis_value(gyro_bias[0], spread), axis_value(gyro_bias[1], spread),
                            axis_value(gyro_bias[2], spread), axis_value(accel_bias[0], spread),
                            axis_value(accel_bias[1], spread), axis_value(accel_bias[2], spread));
    endfunction

    // mix of deadband edges, moderate motion and full-scale values
    function automatic int motion_spread();
        case ($urandom_range(0, 3))
            0: return 1100;
            1: return 40000;
            default: return 8000;
        endcase
    endfunction

    function automatic t_imu_reading motion_reading();
        return make_reading(1'b0,
                            axis_value(gyro_bias[0], motion_spread()),
                            axis_value(gyro_bias[1], motion_spread()),
                            axis_value(gyro_bias[2], motion_spread()),
                            axis_value(accel_bias[0], motion_spread()),
                            axis_value(accel_bias[1], motion_spread()),
                            axis_value(accel_bias[2], motion_spread()));
    endfunction

    // present one request and hold it until accepted
    task automatic send_reading(input t_imu_reading r);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        recalibrate <= r.recal;
        gyro_x      <= r.gyro_x;
        gyro_y      <= r.gyro_y;
        gyro_z      <= r.gyro_z;
        accel_x     <= r.accel_x;
        accel_y     <= r.accel_y;
        accel_z     <= r.accel_z;
        do @(posedge clk); while (!in_ready);
        if (!r.recal) begin
            readings_sent++;
        end
    endtask

    // hold off requests until every predicted result is out and the lanes are empty
    task automatic drain_results(input int settle);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_sensitivity(input logic [SENS_W-1:0] value);
        drain_results(SETTLE_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // recalibrate, optionally break off the window, then a full window and the averaging request
    task automatic run_calibration();
        int spread;
        int cut;
        spread = $urandom_range(0, 1500);
        for (int k = 0; k < 3; k++) begin
            gyro_bias[k]  = int'($urandom_range(0, 40000)) - 20000;
            accel_bias[k] = int'($urandom_range(0, 32000)) - 16000;
        end
        accel_bias[2] += ONE_G;
        send_reading(noise_reading(1'b1));
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, WINDOW);
            repeat (cut) send_reading(window_reading(spread));
            send_reading(noise_reading(1'b1));
        end
        repeat (WINDOW) send_reading(window_reading(spread));
        send_reading(noise_reading(1'b0));
    endtask

    // output stalls in random bursts
    initial begin
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(1, 11) - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // hard stop if the run hangs
    initial begin
        #2ms;
        $display("imu_offset_calibrate_scale_unit verification failed");
        $finish;
    end

    initial begin
        int phase;
        int burst;
        logic [SENS_W-1:0] sens;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // recalibrate from reset, then a window broken off after ten requests
        send_reading(make_reading(1'b1, -1, -1, -1, -1, -1, -1));
        repeat (10) send_reading(make_reading(1'b0, 32767, -32768, 32767, -32768, 32767, -32768));
        send_reading(make_reading(1'b1, 0, 0, 0, 0, 0, 0));

        // window whose averages truncate toward zero: offsets -1, 1, -512, 511, -512, 0
        send_reading(make_reading(1'b0, -100, 100, -32768, 32767, -32768, 0));
        repeat (WINDOW - 1) send_reading(make_reading(1'b0, 0, 0, 0, 0, 0, 0));
        send_reading(make_reading(1'b0, 32767, 32767, 32767, 32767, 32767, 32767));

        // deadband edges, one g on z and full-scale saturation
        send_reading(make_reading(1'b0, 998, 1000, 487, 511, -512, 16384));
        send_reading(make_reading(1'b0, 999, -999, -1512, 32767, 32767, -32768));
        send_reading(make_reading(1'b0, -1000, 0, 0, -32768, 32767, 32767));
        send_reading(make_reading(1'b0, -1001, 1001, -511, 0, 0, 0));
        send_reading(make_reading(1'b0, 32767, 32767, 32767, 32767, 32767, 32767));
        send_reading(make_reading(1'b0, -32768, -32768, -32768, -32768, -32768, -32768));

        // zero sensitivity
        write_sensitivity('0);
        send_reading(make_reading(1'b0, 32767, 32767, 32767, 0, 0, 0));
        send_reading(make_reading(1'b0, -32768, -32768, -32768, 0, 0, 0));

        // largest and smallest sensitivity
        write_sensitivity('1);
        send_reading(make_reading(1'b0, 999, -1001, 2000, 1, -1, 1));
        write_sensitivity(16'd1);
        send_reading(make_reading(1'b0, 32767, 32767, 32767, 0, 0, 0));
        send_reading(make_reading(1'b0, -32768, -32768, -32768, 0, 0, 0));

        // random phases: register setting, optional recalibration, run of motion requests
        readings_sent = 0;
        phase = 0;
        while (readings_sent < RANDOM_ITEMS) begin
            phase++;
            idle_on = (readings_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            case (phase)
                1: sens = '0;
                2: sens = '1;
                3: sens = 16'd1;
                4: sens = SENS_RESET;
                default: sens = SENS_W'($urandom_range(0, 65535));
            endcase
            if (phase <= 4 || $urandom_range(0, 2) != 0) begin
                write_sensitivity(sens);
            end
            if (phase == 1 || $urandom_range(0, 1) == 0) begin
                run_calibration();
            end
            burst = $urandom_range(40, 200);
            for (int n = 0; n < burst && readings_sent < RANDOM_ITEMS; n++) begin
                if (readings_sent >= RANDOM_ITEMS - CALM_TAIL) begin
                    idle_on = 1'b0;
                end
                if ($urandom_range(0, 99) == 0) begin
                    run_calibration();
                end else begin
                    send_reading(motion_reading());
                end
            end
        end

        // wait out the last results, then the pipeline depth
        drain_results(END_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("imu_offset_calibrate_scale_unit verification clean");
        end else begin
            $display("imu_offset_calibrate_scale_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/imuocs_pkg.sv
hw/rtl/imuocs_lane.sv
hw/rtl/imu_offset_calibrate_scale_unit.sv
tb/sv/imuocs_checker.sv
tb/sv/testbench.sv
